FILE: hw/rtl/arpc_pkg.sv
// Shared types, constants and codes for the ARP cache table with aging.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

  // Table size and register defaults.
  localparam int unsigned DEFAULT_ENTRIES = 16;
  localparam logic [7:0]  TIMEOUT_RESET   = 8'd15;
  localparam logic [7:0]  AGE_MAX         = 8'hFF;
  localparam logic [4:0]  COUNT_MAX       = 5'd31;
  localparam int unsigned SLOT_W          = 4;

  // Item actions; the fourth code does nothing.
  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_TICK   = 2'd2
  } action_e;

  // One input beat.
  typedef struct packed {
    action_e     action;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } arp_req_t;

  // One result beat.
  typedef struct packed {
    logic              found;
    logic [47:0]       mac_out;
    logic [SLOT_W-1:0] slot;
    logic              table_full;
    logic [4:0]        expired_count;
  } arp_rsp_t;

  // One stored table entry.
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [7:0]  age;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/arpc_ctrl.sv
// Controller state machine that sequences the table scan for each item.
`timescale 1ns / 1ps
`default_nettype none
module arpc_ctrl
  import arpc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  output logic           res_valid_o,
  output ctrl_cmd_t      cmd_o,
  input  wire dp_sts_t   sts_i
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  // An item is taken whenever no scan is running.
  assign accept = start && !busy;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = start ? ST_SCAN : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs. The result cycle also accepts the next item.
  always_comb begin
    busy        = 1'b0;
    res_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
      end
      ST_SCAN: begin
        busy       = 1'b1;
        cmd_o.step = 1'b1;
      end
      ST_DRAIN: begin
        busy = 1'b1;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        cmd_o.load  = accept;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // A result only follows the drain of the last entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q) == ST_DRAIN)
    else $error("result strobe without a finished scan");

  // An accepted item always starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_SCAN && busy)
    else $error("accepted item did not start a scan");

  // The scan ends right after the last read is issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && sts_i.last) |=> state_q == ST_DRAIN)
    else $error("scan did not end after the last entry");

endmodule
`default_nettype wire

FILE: hw/rtl/arpc_dp.sv
// Datapath: table memory, valid bits, scan counter and result accumulation.
`timescale 1ns / 1ps
`default_nettype none
module arpc_dp
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES,
  localparam int unsigned IDX_W  = $clog2(ENTRIES)
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ctrl_cmd_t  cmd_i,
  output dp_sts_t         sts_o,
  input  wire arp_req_t   req_i,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_data_i,
  output arp_rsp_t        rsp_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  arp_req_t           req_q;
  logic [7:0]         timeout_q;
  logic [IDX_W-1:0]   cnt_q;
  logic               proc_en_q;
  logic               proc_last_q;
  logic [IDX_W-1:0]   proc_idx_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic               placed_q, placed_d;
  arp_rsp_t           rsp_q, rsp_d;

  logic               wr_en;
  entry_t             wr_entry;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_entry;
  logic               cur_valid;
  logic [7:0]         age_inc;
  logic [SLOT_W-1:0]  cur_slot;

  // Scan status for the controller.
  assign sts_o.last = cmd_i.step && (cnt_q == LAST_IDX);

  // Entry store, one read a cycle during the scan.
  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (proc_idx_q),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.step),
    .raddr_i (cnt_q),
    .rdata_o (rd_data)
  );

  assign rd_entry  = entry_t'(rd_data);
  assign cur_valid = valid_q[proc_idx_q];
  assign cur_slot  = SLOT_W'(proc_idx_q);
  assign age_inc   = (rd_entry.age == AGE_MAX) ? AGE_MAX : rd_entry.age + 8'd1;

  // Timeout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  // Item latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // Read counter and the registered stage that follows the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      proc_en_q   <= 1'b0;
      proc_last_q <= 1'b0;
      proc_idx_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      proc_en_q   <= cmd_i.step;
      proc_last_q <= sts_o.last;
      proc_idx_q  <= cnt_q;
    end
  end

  // Per-entry work on the entry that was just read.
  always_comb begin
    valid_d  = valid_q;
    placed_d = placed_q;
    rsp_d    = rsp_q;
    wr_en    = 1'b0;
    wr_entry = rd_entry;
    if (cmd_i.load) begin
      placed_d = 1'b0;
      rsp_d    = '0;
    end else if (proc_en_q) begin
      unique case (req_q.action)
        ACT_LOOKUP: begin
          // Later hits overwrite earlier ones: highest index wins.
          if (cur_valid && rd_entry.ip == req_q.ip_addr) begin
            rsp_d.found   = 1'b1;
            rsp_d.mac_out = rd_entry.mac;
            rsp_d.slot    = cur_slot;
          end
        end
        ACT_INSERT: begin
          // First free slot in scan order takes the new entry.
          if (!cur_valid && !placed_q) begin
            valid_d[proc_idx_q] = 1'b1;
            placed_d            = 1'b1;
            wr_en               = 1'b1;
            wr_entry.ip         = req_q.ip_addr;
            wr_entry.mac        = req_q.mac_addr;
            wr_entry.age        = '0;
            rsp_d.slot          = cur_slot;
          end else if (proc_last_q && !placed_q) begin
            rsp_d.table_full = 1'b1;
          end
        end
        ACT_TICK: begin
          // Age live entries and drop those past the timeout.
          if (cur_valid) begin
            if (age_inc > timeout_q) begin
              valid_d[proc_idx_q] = 1'b0;
              if (rsp_q.expired_count != COUNT_MAX) begin
                rsp_d.expired_count = rsp_q.expired_count + 5'd1;
              end
            end else begin
              wr_en        = 1'b1;
              wr_entry.age = age_inc;
            end
          end
        end
        default: begin
          // Unused action code: no state change.
        end
      endcase
    end
  end

  // Valid bits and insert flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      placed_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      placed_q <= placed_d;
    end
  end

  // Result accumulator.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

  // A tick never brings an entry to life.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_en_q && !cmd_i.load && req_q.action == ACT_TICK)
      |=> $countones(valid_q) <= $past($countones(valid_q)))
    else $error("tick raised a valid bit");

  // An insert adds at most one entry and removes none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_en_q && !cmd_i.load && req_q.action == ACT_INSERT)
      |=> ($countones(valid_q) == $past($countones(valid_q))
           || $countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("insert changed more than one valid bit");

  // Each new item starts its scan at the first entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> cnt_q == '0 && !placed_q)
    else $error("scan did not restart at entry zero");

endmodule
`default_nettype wire

FILE: hw/rtl/arp_cache_table_with_aging_unit.sv
// Top level of the ARP cache table with aging: controller plus datapath.
// An accepted item moves the controller through SCAN, where every entry is
// read in turn, and DRAIN; the result strobe is high in the DONE state.
// A new item is not taken while a scan runs; the next item is accepted in
// the result cycle. The scan reads one entry per cycle through the single
// read port of the entry memory.
// Reset clears all valid bits at once and sets the timeout to 15; no sweep.
// Results are shown for one cycle only; the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none
module arp_cache_table_with_aging_unit
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire arp_req_t   req_i,
  output logic            res_valid_o,
  output arp_rsp_t        rsp_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Timeout writes are taken whenever no scan is running.
  assign cfg_ready_o = !busy;

  // Sequencer.
  arpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Table storage and per-entry logic.
  arpc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp_o)
  );

endmodule
`default_nettype wire

FILE: tb/tb_arp_cache_table_with_aging_unit.sv
// Self-checking testbench for the ARP cache table with aging: table-driven and random items.
`timescale 1ns / 1ps
module tb_arp_cache_table_with_aging_unit;
  import arpc_pkg::*;

  localparam int unsigned N_SLOTS    = DEFAULT_ENTRIES;
  localparam int unsigned STALL_MAX  = 4000;
  localparam int unsigned SETTLE_CYC = N_SLOTS + 6;
  // The fourth action code is a no-op in the block.
  localparam action_e     ACT_NONE   = action_e'(2'b11);

  // One row of the directed table: either a timeout write or one item.
  typedef struct packed {
    logic       is_cfg;
    logic [7:0] cfg_val;
    arp_req_t   req;
    logic       has_exp;
    arp_rsp_t   exp;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  arp_req_t    req_i;
  logic        res_valid_o;
  arp_rsp_t    rsp_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  // Shadow copy of the table and the timeout register.
  logic        tbl_valid [N_SLOTS];
  logic [31:0] tbl_ip    [N_SLOTS];
  logic [47:0] tbl_mac   [N_SLOTS];
  logic [7:0]  tbl_age   [N_SLOTS];
  logic [7:0]  timeout_q;

  arp_rsp_t    pending_rsp [$];
  stim_row_t   dir_rows [$];
  logic [31:0] ip_pool [8];
  int unsigned mismatch_cnt;
  int unsigned item_no;
  int unsigned stall_cnt;

  arp_cache_table_with_aging_unit #(
    .ENTRIES(N_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Computes the result of one item and updates the shadow table.
  function automatic arp_rsp_t arp_predict(input arp_req_t r);
    arp_rsp_t o;
    logic     placed;
    o = '0;
    placed = 1'b0;
    case (r.action)
      ACT_LOOKUP: begin
        // The highest matching slot wins.
        for (int i = 0; i < N_SLOTS; i++) begin
          if (tbl_valid[i] && tbl_ip[i] == r.ip_addr) begin
            o.found   = 1'b1;
            o.mac_out = tbl_mac[i];
            o.slot    = SLOT_W'(i);
          end
        end
      end
      ACT_INSERT: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (!placed && !tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_ip[i]    = r.ip_addr;
            tbl_mac[i]   = r.mac_addr;
            tbl_age[i]   = '0;
            o.slot       = SLOT_W'(i);
            placed       = 1'b1;
          end
        end
        o.table_full = !placed;
      end
      ACT_TICK: begin
        // Age saturates; entries past the timeout are dropped.
        for (int i = 0; i < N_SLOTS; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + 8'd1;
            if (tbl_age[i] > timeout_q) begin
              tbl_valid[i] = 1'b0;
              if (o.expired_count != COUNT_MAX) o.expired_count = o.expired_count + 5'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  function automatic arp_rsp_t mk_rsp(input logic f, input logic [47:0] m,
                                      input logic [SLOT_W-1:0] s, input logic full,
                                      input logic [4:0] cnt);
    arp_rsp_t o;
    o.found         = f;
    o.mac_out       = m;
    o.slot          = s;
    o.table_full    = full;
    o.expired_count = cnt;
    return o;
  endfunction

  function automatic void add_item(input action_e a, input logic [31:0] ip,
                                   input logic [47:0] mac, input logic has_exp,
                                   input arp_rsp_t exp);
    stim_row_t row;
    row = '0;
    row.req.action   = a;
    row.req.ip_addr  = ip;
    row.req.mac_addr = mac;
    row.has_exp      = has_exp;
    row.exp          = exp;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [7:0] v);
    stim_row_t row;
    row = '0;
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    dir_rows.push_back(row);
  endfunction

  // Random item; most addresses come from a small pool so lookups hit.
  function automatic arp_req_t gen_item(input int unsigned tick_pct);
    arp_req_t    r;
    int unsigned pick;
    pick       = $urandom_range(99);
    r.ip_addr  = ($urandom_range(99) < 75) ? ip_pool[$urandom_range(7)] : $urandom;
    r.mac_addr = 48'({$urandom, $urandom});
    if (pick < 3) r.action = ACT_NONE;
    else if (pick < 3 + tick_pct) r.action = ACT_TICK;
    else if ($urandom_range(99) < 55) r.action = ACT_LOOKUP;
    else r.action = ACT_INSERT;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [47:0] e,
                                      input logic [47:0] a);
    if (e !== a) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, e, a);
      mismatch_cnt++;
    end
  endfunction

  // Presents one item and waits for the beat; random gaps go in front of it.
  task automatic send_item(input arp_req_t r, input logic has_exp, input arp_rsp_t exp);
    arp_rsp_t p;
    if (!(item_no >= 700 && item_no < 1000) && $urandom_range(99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    p = arp_predict(r);
    pending_rsp.push_back(has_exp ? exp : p);
    item_no++;
  endtask

  // Lets every outstanding result arrive, then lets the block settle.
  task automatic drain;
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [7:0] v);
    repeat ($urandom_range(0, 3)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    timeout_q = v;
    cfg_valid_i <= 1'b0;
  endtask

  // Result checker: every strobed beat must match the oldest expectation.
  always @(posedge clk_i) begin : rsp_check
    arp_rsp_t e;
    if (rst_ni && res_valid_o) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, actual %0h", $time, rsp_o);
        mismatch_cnt++;
      end else begin
        e = pending_rsp.pop_front();
        check_field("found", 48'(e.found), 48'(rsp_o.found));
        check_field("mac_out", e.mac_out, rsp_o.mac_out);
        check_field("slot", 48'(e.slot), 48'(rsp_o.slot));
        check_field("table_full", 48'(e.table_full), 48'(rsp_o.table_full));
        check_field("expired_count", 48'(e.expired_count), 48'(rsp_o.expired_count));
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("arp_cache_table_with_aging_unit: mismatch");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    logic [7:0]  phase_to  [6];
    int unsigned phase_len [6];
    int unsigned phase_tk  [6];
    arp_req_t    r;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    mismatch_cnt = 0;
    item_no      = 0;
    stall_cnt    = 0;
    timeout_q    = TIMEOUT_RESET;
    for (int i = 0; i < N_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i]    = '0;
      tbl_mac[i]   = '0;
      tbl_age[i]   = '0;
    end

    // Directed table: misses, the no-op code, duplicates, full table, mass expiry.
    add_item(ACT_LOOKUP, 32'h0, 48'h0, 1'b1, mk_rsp(0, 48'h0, 0, 0, 0));
    add_item(ACT_NONE, '1, '1, 1'b1, mk_rsp(0, 48'h0, 0, 0, 0));
    add_item(ACT_INSERT, '1, '1, 1'b1, mk_rsp(0, 48'h0, 0, 0, 0));
    add_item(ACT_INSERT, 32'h0, 48'h0, 1'b1, mk_rsp(0, 48'h0, 1, 0, 0));
    add_item(ACT_LOOKUP, '1, 48'h0, 1'b1, mk_rsp(1, '1, 0, 0, 0));
    add_item(ACT_LOOKUP, 32'h0, '1, 1'b1, mk_rsp(1, 48'h0, 1, 0, 0));
    add_item(ACT_INSERT, 32'h0, 48'h1234_5678_9ABC, 1'b1, mk_rsp(0, 48'h0, 2, 0, 0));
    add_item(ACT_LOOKUP, 32'h0, 48'h0, 1'b1, mk_rsp(1, 48'h1234_5678_9ABC, 2, 0, 0));
    add_item(ACT_TICK, 32'h0, 48'h0, 1'b1, mk_rsp(0, 48'h0, 0, 0, 0));
    for (int i = 3; i < N_SLOTS; i++) begin
      add_item(ACT_INSERT, 32'hA5A5_0000 + i, {16'h5A5A, 32'(i)}, 1'b0, '0);
    end
    add_item(ACT_INSERT, 32'h1, 48'h1, 1'b1, mk_rsp(0, 48'h0, 0, 1, 0));
    add_item(ACT_LOOKUP, 32'hA5A5_000F, 48'h0, 1'b0, '0);
    add_cfg(8'd0);
    add_item(ACT_TICK, 32'h0, 48'h0, 1'b1, mk_rsp(0, 48'h0, 0, 0, 5'(N_SLOTS)));
    add_item(ACT_LOOKUP, '1, 48'h0, 1'b1, mk_rsp(0, 48'h0, 0, 0, 0));

    // Random phases: timeout, item count and share of ticks in percent.
    phase_to  = '{8'd15, 8'd0, 8'd1, 8'd255, 8'd254, 8'($urandom_range(2, 253))};
    phase_len = '{400, 150, 150, 550, 100, 350};
    phase_tk  = '{25, 30, 35, 60, 20, 30};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        drain();
        write_timeout(dir_rows[k].cfg_val);
      end else begin
        send_item(dir_rows[k].req, dir_rows[k].has_exp, dir_rows[k].exp);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_timeout(phase_to[ph]);
      foreach (ip_pool[k]) ip_pool[k] = $urandom;
      ip_pool[0] = 32'h0;
      ip_pool[1] = '1;
      for (int n = 0; n < phase_len[ph]; n++) begin
        r = gen_item(phase_tk[ph]);
        send_item(r, 1'b0, '0);
      end
    end

    drain();
    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("arp_cache_table_with_aging_unit: match");
    end else begin
      $display("arp_cache_table_with_aging_unit: mismatch");
    end
    $finish;
  end

endmodule
